>>> sv/lcs_pkg.sv
// shared types and constants of the led cube layer scan driver
package lcs_pkg;

  localparam int unsigned NUM_LAYERS_DEF  = 8;
  localparam int unsigned NUM_COLUMNS_DEF = 8;
  localparam int unsigned BYTE_W          = 8;

  // host operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_SEL,
    ST_COL_RD,
    ST_COL_OUT
  } state_e;

  // one input beat
  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        layer;
    logic [2:0]        column;
    logic [2:0]        bit_index;
    logic [BYTE_W-1:0] value;
  } item_t;

  // one output beat
  typedef struct packed {
    logic [BYTE_W-1:0] shift_byte;
    logic              last;
  } beat_t;

  // frame store controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } store_ctrl_t;

  // output register load request
  typedef struct packed {
    logic  load;
    beat_t beat;
  } out_load_t;

endpackage

>>> sv/lcs_store.sv
// frame store memory with per-entry valid bits and registered read port
module lcs_store #(
  parameter int unsigned NumLayers  = lcs_pkg::NUM_LAYERS_DEF,
  parameter int unsigned NumColumns = lcs_pkg::NUM_COLUMNS_DEF,
  localparam int unsigned Depth     = NumLayers * NumColumns,
  localparam int unsigned AddrW     = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lcs_pkg::store_ctrl_t        ctrl_i,
  input  logic [AddrW-1:0]            addr_i,
  input  logic [lcs_pkg::BYTE_W-1:0]  wdata_i,
  output logic [lcs_pkg::BYTE_W-1:0]  rdata_o
);

  logic [lcs_pkg::BYTE_W-1:0] mem_q [Depth];
  logic [lcs_pkg::BYTE_W-1:0] rd_q;
  logic [Depth-1:0]           vld_q;
  logic                       rd_vld_q;

  // single port memory, read data registered
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[addr_i];
    end
  end

  // valid bits stand in for clearing the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr_all) begin
        vld_q <= '0;
      end else if (ctrl_i.wr_en) begin
        vld_q[addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[addr_i];
      end
    end
  end

  // an entry never written since the last clear reads as zero
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/lcs_seq.sv
// sequencer: host operations, byte merge and the scan walk over one layer
module lcs_seq #(
  parameter int unsigned NumLayers  = lcs_pkg::NUM_LAYERS_DEF,
  parameter int unsigned NumColumns = lcs_pkg::NUM_COLUMNS_DEF,
  localparam int unsigned AddrW     = $clog2(NumLayers * NumColumns),
  localparam int unsigned LayerW    = $clog2(NumLayers),
  localparam int unsigned ColW      = (NumColumns > 1) ? $clog2(NumColumns) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  lcs_pkg::item_t              in_data_i,
  output logic                        in_stall_o,
  input  logic                        slot_free_i,
  output lcs_pkg::out_load_t          out_load_o,
  output lcs_pkg::store_ctrl_t        store_ctrl_o,
  output logic [AddrW-1:0]            store_addr_o,
  output logic [lcs_pkg::BYTE_W-1:0]  store_wdata_o,
  input  logic [lcs_pkg::BYTE_W-1:0]  store_rdata_i
);

  lcs_pkg::state_e    state_q, state_d;
  lcs_pkg::item_t     item_q;
  logic [LayerW-1:0]  scan_layer_q;
  logic [ColW-1:0]    scan_col_q;
  logic               accept;
  logic               addr_ok_in;
  logic               last_col;
  logic [AddrW-1:0]   item_addr;
  logic [AddrW-1:0]   scan_addr;

  assign accept     = in_valid_i && (state_q == lcs_pkg::ST_IDLE);
  assign in_stall_o = (state_q != lcs_pkg::ST_IDLE);
  assign addr_ok_in = (32'(in_data_i.layer) < NumLayers) &&
                      (32'(in_data_i.column) < NumColumns);
  assign last_col   = (32'(scan_col_q) == NumColumns - 1);
  assign item_addr  = AddrW'(32'(item_q.layer) * NumColumns + 32'(item_q.column));
  assign scan_addr  = AddrW'(32'(scan_layer_q) * NumColumns + 32'(scan_col_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcs_pkg::ST_IDLE: begin
        if (accept) begin
          case (lcs_pkg::op_e'(in_data_i.mode))
            lcs_pkg::OP_WRITE,
            lcs_pkg::OP_SET:   state_d = addr_ok_in ? lcs_pkg::ST_RMW_RD : lcs_pkg::ST_IDLE;
            lcs_pkg::OP_CLEAR: state_d = lcs_pkg::ST_CLEAR;
            lcs_pkg::OP_SCAN:  state_d = lcs_pkg::ST_SEL;
            default:           state_d = lcs_pkg::ST_IDLE;
          endcase
        end
      end
      lcs_pkg::ST_CLEAR:  state_d = lcs_pkg::ST_IDLE;
      lcs_pkg::ST_RMW_RD: state_d = lcs_pkg::ST_RMW_WR;
      lcs_pkg::ST_RMW_WR: state_d = lcs_pkg::ST_IDLE;
      lcs_pkg::ST_SEL: begin
        if (slot_free_i) state_d = lcs_pkg::ST_COL_RD;
      end
      lcs_pkg::ST_COL_RD: state_d = lcs_pkg::ST_COL_OUT;
      lcs_pkg::ST_COL_OUT: begin
        if (slot_free_i) state_d = last_col ? lcs_pkg::ST_IDLE : lcs_pkg::ST_COL_RD;
      end
      default: state_d = lcs_pkg::ST_IDLE;
    endcase
  end

  // state outputs: store port, merge unit, output beat
  always_comb begin
    store_ctrl_o  = '0;
    store_addr_o  = item_addr;
    store_wdata_o = item_q.value;
    out_load_o    = '0;
    case (state_q)
      lcs_pkg::ST_CLEAR: store_ctrl_o.clr_all = 1'b1;
      lcs_pkg::ST_RMW_RD: store_ctrl_o.rd_en = 1'b1;
      lcs_pkg::ST_RMW_WR: begin
        store_ctrl_o.wr_en = 1'b1;
        if (lcs_pkg::op_e'(item_q.mode) == lcs_pkg::OP_SET) begin
          store_wdata_o = store_rdata_i | (lcs_pkg::BYTE_W'(1) << item_q.bit_index);
        end
      end
      lcs_pkg::ST_SEL: begin
        out_load_o.load            = slot_free_i;
        out_load_o.beat.shift_byte = lcs_pkg::BYTE_W'(1) << scan_layer_q;
        out_load_o.beat.last       = 1'b0;
      end
      lcs_pkg::ST_COL_RD: begin
        store_ctrl_o.rd_en = 1'b1;
        store_addr_o       = scan_addr;
      end
      lcs_pkg::ST_COL_OUT: begin
        store_addr_o               = scan_addr;
        out_load_o.load            = slot_free_i;
        out_load_o.beat.shift_byte = store_rdata_i;
        out_load_o.beat.last       = last_col;
      end
      default: ;
    endcase
  end

  // state and scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lcs_pkg::ST_IDLE;
      scan_layer_q <= '0;
      scan_col_q   <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == lcs_pkg::ST_COL_OUT) && slot_free_i) begin
        if (last_col) begin
          scan_col_q   <= '0;
          scan_layer_q <= (scan_layer_q == LayerW'(NumLayers - 1)) ? '0
                          : scan_layer_q + LayerW'(1);
        end else begin
          scan_col_q <= scan_col_q + ColW'(1);
        end
      end
    end
  end

  // item holding register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // column counter stays inside the layer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_col_q) < NumColumns)
    else $error("scan column out of range");

  // a write to a missing entry leaves the store alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !addr_ok_in &&
     ((in_data_i.mode == lcs_pkg::OP_WRITE) || (in_data_i.mode == lcs_pkg::OP_SET)))
    |=> (state_q == lcs_pkg::ST_IDLE))
    else $error("out of range store access not dropped");

  // the final column beat ends the scan and moves the layer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o.load && out_load_o.beat.last)
    |=> (state_q == lcs_pkg::ST_IDLE) && (scan_layer_q != $past(scan_layer_q)))
    else $error("scan did not finish after last beat");

  // column data only follows its read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcs_pkg::ST_COL_OUT)
    |-> ($past(state_q) == lcs_pkg::ST_COL_RD) || ($past(state_q) == lcs_pkg::ST_COL_OUT))
    else $error("column beat without store read");

endmodule

>>> sv/led_cube_layer_scan_driver.sv
// top level of the led cube layer scan driver with its output register
//
//   channel  direction  payload          handshake
//   in       input      lcs_pkg::item_t  in_valid_i / in_stall_o
//   out      output     lcs_pkg::beat_t  out_valid_o / out_stall_i
//
// write byte and set voxel go through a store read state and then a store write
// state; clear store goes through one clear state, and an out of range write or
// set is dropped at once. a scan tick selects the layer, then reads and sends
// each column in turn: the single store port gives one column read at a time.
// reset clears the sequencer, the layer counter and the store's valid bits at
// once; no clearing pass is needed. output stall holds the sequencer while a
// beat waits, and the input is stalled for the whole of each operation.
module led_cube_layer_scan_driver #(
  parameter int unsigned NumLayers  = lcs_pkg::NUM_LAYERS_DEF,
  parameter int unsigned NumColumns = lcs_pkg::NUM_COLUMNS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  lcs_pkg::item_t  in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output lcs_pkg::beat_t  out_data_o,
  input  logic            out_stall_i
);

  localparam int unsigned AddrW = $clog2(NumLayers * NumColumns);

  lcs_pkg::store_ctrl_t        store_ctrl;
  logic [AddrW-1:0]            store_addr;
  logic [lcs_pkg::BYTE_W-1:0]  store_wdata;
  logic [lcs_pkg::BYTE_W-1:0]  store_rdata;
  lcs_pkg::out_load_t          out_load;
  logic                        slot_free;
  logic                        out_valid_q;
  lcs_pkg::beat_t              out_data_q;

  assign slot_free = !out_valid_q || !out_stall_i;

  lcs_seq #(
    .NumLayers  (NumLayers),
    .NumColumns (NumColumns)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .slot_free_i   (slot_free),
    .out_load_o    (out_load),
    .store_ctrl_o  (store_ctrl),
    .store_addr_o  (store_addr),
    .store_wdata_o (store_wdata),
    .store_rdata_i (store_rdata)
  );

  lcs_store #(
    .NumLayers  (NumLayers),
    .NumColumns (NumColumns)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (store_ctrl),
    .addr_i  (store_addr),
    .wdata_i (store_wdata),
    .rdata_o (store_rdata)
  );

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (out_load.load) begin
      out_data_q <= out_load.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
